/* hdl/a64x_pkg.sv */
// Package for the AArch64 subset execute unit: opcodes, request codes, decoded
// record and result record. Used by every module in hdl/.
package a64x_pkg;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,  OP_AND  = 5'd1,  OP_B     = 5'd2,  OP_BL    = 5'd3,
        OP_CBZ   = 5'd4,  OP_CMP  = 5'd5,  OP_LDR   = 5'd6,  OP_MOV   = 5'd7,
        OP_SUB   = 5'd8,  OP_MOVZ = 5'd9,  OP_MUL   = 5'd10, OP_NEG   = 5'd11,
        OP_ORR   = 5'd12, OP_STP  = 5'd13, OP_STR   = 5'd14, OP_STRB  = 5'd15,
        OP_STUR  = 5'd16, OP_STURB = 5'd17, OP_SXTW = 5'd18, OP_LDRET = 5'd19
    } op_t;

    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [63:0] SIGN64   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] LINK_INC = 64'd4;
    localparam logic [4:0]  LINK_REG = 5'd30;

    // Instruction after the front end: opcode checked against its form.
    typedef struct packed {
        logic        unsup;
        op_t         op;
        logic        wide;
        logic [4:0]  rd;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic        use_index;
        logic [63:0] imm;
        logic [63:0] disp;
        logic        wb;
        logic [63:0] pc;
        logic [31:0] ldata;
    } instr_t;

    typedef struct packed {
        logic [1:0]  mem_request;
        logic        mem_byte;
        logic [63:0] mem_address;
        logic [31:0] mem_wdata;
        logic        branch_taken;
        logic [63:0] branch_target;
        logic        unsupported;
        logic        last_result;
    } result_t;

    // Bit 0: 32-bit form allowed, bit 1: 64-bit form allowed.
    function automatic logic form_ok(input logic [4:0] op, input logic wide);
        logic [1:0] f;
        begin
            unique case (op)
                OP_ADD, OP_CBZ, OP_CMP, OP_SUB, OP_SXTW: f = 2'b10;
                OP_AND, OP_B, OP_BL, OP_LDRET:           f = 2'b11;
                OP_LDR, OP_MOV, OP_MOVZ, OP_MUL, OP_NEG, OP_ORR, OP_STP,
                OP_STR, OP_STRB, OP_STUR, OP_STURB:      f = 2'b01;
                default:                                 f = 2'b00;
            endcase
            form_ok = f[wide];
        end
    endfunction

endpackage

/* hdl/a64x_front.sv */
// Front end: accepts instruction items, classifies opcode/form, and buffers
// them in a two-entry queue toward the back end. Uses a64x_pkg.
module a64x_front
    import a64x_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  instr_t       in_instr,
    output logic         q_valid,
    input  logic         q_ready,
    output instr_t       q_instr
);

    instr_t     mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;
    instr_t     in_cls;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_instr  = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        in_cls       = in_instr;
        in_cls.unsup = !form_ok(in_instr.op, in_instr.wide);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cls;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* hdl/a64x_back.sv */
// Back end: register file, flags and execution of one instruction per cycle
// while its output register is free, plus a second STP beat. Uses a64x_pkg.
module a64x_back
    import a64x_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    output logic    q_ready,
    input  instr_t  q_instr,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic [63:0] rf_reg [32];
    logic [3:0]  flags_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        pend_reg;      // second STP beat waiting
    result_t     pend_data_reg;

    logic        out_free, take;
    logic [63:0] a, b, d, addr, x_res, cmp_r;
    logic        x_we, base_we;
    logic [4:0]  x_rd;
    result_t     r0, r1;
    logic [3:0]  flags_next;
    logic [63:0] prod;

    assign out_free   = !out_valid_reg || out_ready;
    assign q_ready    = out_free && !pend_reg;
    assign take       = q_valid && q_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    assign a    = rf_reg[q_instr.ra];
    assign b    = rf_reg[q_instr.rb];
    assign d    = rf_reg[q_instr.rd];
    assign prod = a[31:0] * b[31:0];

    always_comb begin
        r0         = '0;
        r0.last_result = 1'b1;
        r1         = '0;
        x_we       = 1'b0;
        x_rd       = q_instr.rd;
        x_res      = '0;
        base_we    = 1'b0;
        addr       = a + q_instr.disp;
        cmp_r      = d - q_instr.imm;
        flags_next = flags_reg;
        if (q_instr.unsup) begin
            r0.unsupported = 1'b1;
        end else begin
            unique case (q_instr.op)
                OP_ADD: begin x_we = 1'b1; x_res = a + b; end
                OP_SUB: begin x_we = 1'b1; x_res = a - b; end
                OP_AND: begin
                    x_we  = 1'b1;
                    x_res = q_instr.wide ? (a & q_instr.imm)
                                         : {32'd0, a[31:0] & q_instr.imm[31:0]};
                end
                OP_B: begin
                    r0.branch_taken = 1'b1; r0.branch_target = q_instr.imm;
                end
                OP_BL: begin
                    r0.branch_taken = 1'b1; r0.branch_target = q_instr.imm;
                    x_we = 1'b1; x_rd = LINK_REG; x_res = q_instr.pc + LINK_INC;
                end
                OP_CBZ: begin
                    if (d == 64'd0) begin
                        r0.branch_taken = 1'b1; r0.branch_target = q_instr.imm;
                    end
                end
                OP_CMP: begin
                    flags_next = {cmp_r[63], cmp_r == 64'd0, d >= q_instr.imm,
                                  |((d ^ q_instr.imm) & (d ^ cmp_r) & SIGN64)};
                end
                OP_LDR: begin
                    r0.mem_request = REQ_READ; r0.mem_address = addr;
                    base_we = q_instr.wb;
                end
                OP_MOV:  begin x_we = 1'b1; x_res = {32'd0, a[31:0]}; end
                OP_MOVZ: begin x_we = 1'b1; x_res = {32'd0, q_instr.imm[31:0]}; end
                OP_MUL:  begin x_we = 1'b1; x_res = {32'd0, prod[31:0]}; end
                OP_NEG:  begin x_we = 1'b1; x_res = {32'd0, 32'd0 - a[31:0]}; end
                OP_ORR: begin
                    x_we = 1'b1; x_res = {32'd0, a[31:0] | q_instr.imm[31:0]};
                end
                OP_STP: begin
                    r0.mem_request = REQ_WRITE; r0.mem_address = addr;
                    r0.mem_wdata = d[31:0]; r0.last_result = 1'b0;
                    r1.mem_request = REQ_WRITE; r1.mem_address = addr + LINK_INC;
                    r1.mem_wdata = b[31:0]; r1.last_result = 1'b1;
                end
                OP_STR, OP_STUR: begin
                    r0.mem_request = REQ_WRITE; r0.mem_address = addr;
                    r0.mem_wdata = d[31:0];
                end
                OP_STRB: begin
                    r0.mem_request = REQ_WRITE; r0.mem_byte = 1'b1;
                    r0.mem_address = addr; r0.mem_wdata = {24'd0, d[7:0]};
                    base_we = q_instr.wb;
                end
                OP_STURB: begin
                    r0.mem_request = REQ_WRITE; r0.mem_byte = 1'b1;
                    r0.mem_address = q_instr.use_index ? addr + b : addr;
                    r0.mem_wdata = {24'd0, d[7:0]};
                end
                OP_SXTW: begin
                    x_we = 1'b1; x_res = {{32{a[31]}}, a[31:0]};
                end
                OP_LDRET: begin x_we = 1'b1; x_res = {32'd0, q_instr.ldata}; end
                default: r0.unsupported = 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 32; i++) rf_reg[i] <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            if (take) begin
                if (base_we) rf_reg[q_instr.ra] <= addr;
                if (x_we)    rf_reg[x_rd]       <= x_res;
                flags_reg <= flags_next;
            end
            if (out_free) begin
                if (pend_reg) begin
                    out_reg       <= pend_data_reg;
                    out_valid_reg <= 1'b1;
                    pend_reg      <= 1'b0;
                end else begin
                    out_valid_reg <= take;
                    if (take) begin
                        out_reg  <= r0;
                        pend_reg <= !q_instr.unsup && (q_instr.op == OP_STP);
                        pend_data_reg <= r1;
                    end
                end
            end
        end
    end

endmodule

/* hdl/arm64_subset_execute_unit_core.sv */
// Top level of the AArch64 subset execute unit: front end queue plus back end.
// Depends on a64x_pkg, a64x_front and a64x_back.
//
// Usage: the slave stream (s_axis_*) carries one pre-decoded instruction per
// item; the master stream (m_axis_*) carries result items, one per
// instruction, two for STP (tlast marks the final one).
// An accepted instruction is written into the queue and then executes from
// the queue into the back end output register, where its result is valid.
// Throughput: one instruction per cycle while the receiver is not stalling;
// STP holds the back end until its second request enters the output register.
// A register write is visible to the next instruction in the queue.
// Reset (aresetn low, synchronous) clears the register file, the flags, the
// queue and the valid bit of the output register.
// When the receiver stalls (m_axis_tready low) the output register holds,
// the back end stops, and the two-entry queue fills before s_axis_tready
// drops.
module arm64_subset_execute_unit_core
    import a64x_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [4:0] opcode, [5] wide_form, [10:6] dest_reg, [15:11] src_a_reg,
    // [20:16] src_b_reg, [21] use_index, [85:22] immediate,
    // [149:86] displacement, [150] write_back, [214:151] pc_now,
    // [246:215] load_data, [247] zero fill
    input  logic [247:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [1:0] mem_request, [2] mem_byte, [66:3] mem_address,
    // [98:67] mem_wdata, [99] branch_taken, [163:100] branch_target,
    // [164] unsupported, [167:165] zero fill
    output logic [167:0]  m_axis_tdata,
    output logic          m_axis_tlast
);

    instr_t  in_instr, q_instr;
    logic    q_valid, q_ready;
    result_t res;

    always_comb begin
        in_instr           = '0;
        in_instr.op        = op_t'(s_axis_tdata[4:0]);
        in_instr.wide      = s_axis_tdata[5];
        in_instr.rd        = s_axis_tdata[10:6];
        in_instr.ra        = s_axis_tdata[15:11];
        in_instr.rb        = s_axis_tdata[20:16];
        in_instr.use_index = s_axis_tdata[21];
        in_instr.imm       = s_axis_tdata[85:22];
        in_instr.disp      = s_axis_tdata[149:86];
        in_instr.wb        = s_axis_tdata[150];
        in_instr.pc        = s_axis_tdata[214:151];
        in_instr.ldata     = s_axis_tdata[246:215];
    end

    a64x_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_instr (in_instr),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_instr  (q_instr)
    );

    a64x_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_instr    (q_instr),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (res)
    );

    assign m_axis_tdata = {3'd0, res.unsupported, res.branch_target, res.branch_taken,
                           res.mem_wdata, res.mem_address, res.mem_byte,
                           res.mem_request};
    assign m_axis_tlast = res.last_result;

endmodule
